// File: sv/npc_pkg.sv
package npc_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 256;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COLOR_W = 3 * CHAN_W;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned SQ_W = 2 * CHAN_W;
  localparam int unsigned DIST_W = SQ_W + 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // travels alongside one palette entry through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

// File: sv/npc_palette_mem.sv
module npc_palette_mem #(
  parameter int unsigned PALETTE_ENTRIES = npc_pkg::ENTRIES_DEFAULT,
  parameter int unsigned AW = $clog2(PALETTE_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [npc_pkg::COLOR_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [npc_pkg::COLOR_W-1:0] rdata
);

  logic [npc_pkg::COLOR_W-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/npc_dist.sv
module npc_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  npc_pkg::tag_t               tag_in,
  input  logic [npc_pkg::COLOR_W-1:0] entry,
  input  logic [npc_pkg::CHAN_W-1:0]  q_red,
  input  logic [npc_pkg::CHAN_W-1:0]  q_green,
  input  logic [npc_pkg::CHAN_W-1:0]  q_blue,
  output npc_pkg::tag_t               tag_out,
  output logic [npc_pkg::DIST_W-1:0]  dist_sq
);

  localparam int unsigned CW = npc_pkg::CHAN_W;
  localparam int unsigned SW = npc_pkg::SQ_W;
  localparam int unsigned DW = npc_pkg::DIST_W;

  logic [CW-1:0] er, eg, eb;
  logic [CW-1:0] dr_c, dg_c, db_c;
  logic [CW-1:0] dr, dg, db;
  logic [SW-1:0] sr, sg, sb;
  npc_pkg::tag_t tag1;

  assign er = entry[3*CW-1:2*CW];
  assign eg = entry[2*CW-1:CW];
  assign eb = entry[CW-1:0];

  assign dr_c = (q_red > er) ? q_red - er : er - q_red;
  assign dg_c = (q_green > eg) ? q_green - eg : eg - q_green;
  assign db_c = (q_blue > eb) ? q_blue - eb : eb - q_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid    <= 1'b0;
      tag_out.valid <= 1'b0;
    end else begin
      tag1.valid    <= tag_in.valid;
      tag_out.valid <= tag1.valid;
    end
    tag1.last    <= tag_in.last;
    tag1.idx     <= tag_in.idx;
    tag_out.last <= tag1.last;
    tag_out.idx  <= tag1.idx;
    dr <= dr_c;
    dg <= dg_c;
    db <= db_c;
    sr <= SW'(dr) * SW'(dr);
    sg <= SW'(dg) * SW'(dg);
    sb <= SW'(db) * SW'(db);
  end

  assign dist_sq = DW'(sr) + DW'(sg) + DW'(sb);

endmodule

// File: sv/nearest_palette_color_top.sv
// Write request: taken whenever the block is idle; writes may follow back to back.
// Query request: nearest_index is registered after the last entry is compared and the output is free;
// one palette entry is read per cycle from the single read port of the palette memory.
// A new request is taken after a query only once its result is registered.
// Reset (rst, synchronous) clears control state only; palette contents stay undefined.
module nearest_palette_color_top #(
  parameter int unsigned PALETTE_ENTRIES = npc_pkg::ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             opcode,
  input  logic [npc_pkg::IDX_W-1:0]        entry_index,
  input  logic [npc_pkg::CHAN_W-1:0]       red,
  input  logic [npc_pkg::CHAN_W-1:0]       green,
  input  logic [npc_pkg::CHAN_W-1:0]       blue,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [npc_pkg::IDX_W-1:0]        nearest_index
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
  localparam int unsigned DW = npc_pkg::DIST_W;

  npc_pkg::state_t state, state_next;

  logic                        in_take;
  logic                        is_query;
  logic                        we;
  logic [AW-1:0]               addr;
  logic                        issue;
  logic                        issue_last;
  logic [npc_pkg::COLOR_W-1:0] rdata;
  npc_pkg::tag_t               rtag;
  npc_pkg::tag_t               dtag;
  logic [DW-1:0]               dist_sq;
  logic [npc_pkg::CHAN_W-1:0]  q_red, q_green, q_blue;
  logic [DW-1:0]               best_dist;
  logic [npc_pkg::IDX_W-1:0]   best;
  logic                        out_load;

  assign in_take  = in_valid && !in_stall;
  assign is_query = (opcode == npc_pkg::OP_QUERY);
  assign we = in_take && !is_query && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
  assign issue_last = (addr == LAST_ADDR);

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state)
      npc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && is_query) begin
          state_next = npc_pkg::ST_SCAN;
        end
      end
      npc_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_next = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (dtag.valid && dtag.last) begin
          state_next = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = npc_pkg::ST_IDLE;
        end
      end
      default: state_next = npc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      rtag.valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rtag.valid <= issue;
      if (in_take) begin
        addr <= '0;
      end else if (issue) begin
        addr <= addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    rtag.last <= issue_last;
    rtag.idx  <= npc_pkg::IDX_W'(addr);
    if (in_take) begin
      q_red     <= red;
      q_green   <= green;
      q_blue    <= blue;
      best_dist <= '1;
      best      <= '0;
    end else if (dtag.valid && dist_sq < best_dist) begin
      best_dist <= dist_sq;
      best      <= dtag.idx;
    end
    if (out_load) begin
      nearest_index <= best;
    end
  end

  npc_palette_mem #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .AW(AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(entry_index[AW-1:0]),
    .wdata({red, green, blue}),
    .raddr(addr),
    .rdata(rdata)
  );

  npc_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .tag_in (rtag),
    .entry  (rdata),
    .q_red  (q_red),
    .q_green(q_green),
    .q_blue (q_blue),
    .tag_out(dtag),
    .dist_sq(dist_sq)
  );

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !rtag.valid && !dtag.valid)
    else $error("request taken while scan in flight");

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    in_take && is_query |=> state == npc_pkg::ST_SCAN && addr == '0)
    else $error("query did not start scan at entry zero");

  a_last_in_drain: assert property (@(posedge clk) disable iff (rst)
    dtag.valid && dtag.last |-> state == npc_pkg::ST_DRAIN)
    else $error("last compare outside drain");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_valid || !out_stall)
    else $error("result overwritten while stalled");

endmodule

// File: sim/nearest_palette_color_top_tb.sv
`timescale 1ns / 100ps

module nearest_palette_color_top_tb;
  import npc_pkg::*;

  localparam int unsigned PALETTE_SIZE = ENTRIES_DEFAULT;
  localparam int unsigned CLUSTER_N = 6;

  typedef struct {
    opcode_t          op;
    logic [IDX_W-1:0] idx;
    logic [COLOR_W-1:0] color;
    bit               calm;
  } palette_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  logic [CHAN_W-1:0] red = '0;
  logic [CHAN_W-1:0] green = '0;
  logic [CHAN_W-1:0] blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [IDX_W-1:0] nearest_index;

  palette_req_t req_q[$];
  logic [IDX_W-1:0] expected_index_q[$];
  logic [COLOR_W-1:0] palette_model [PALETTE_SIZE];
  int send_gap = 0;
  int stall_left = 0;
  bit calm_phase = 1'b0;
  int failures = 0;

  nearest_palette_color_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .entry_index   (entry_index),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .nearest_index (nearest_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned chan_sq(input logic [CHAN_W-1:0] a,
                                          input logic [CHAN_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // squared RGB distance, strict less-than keeps the lowest index on ties
  function automatic logic [IDX_W-1:0] closest_entry(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    int unsigned best_dist;
    int unsigned sq_sum;
    logic [IDX_W-1:0] best;
    best = '0;
    best_dist = 32'hFFFF_FFFF;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      sq_sum = chan_sq(r, palette_model[i][23:16]) + chan_sq(g, palette_model[i][15:8]) +
               chan_sq(b, palette_model[i][7:0]);
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best = i[IDX_W-1:0];
      end
    end
    return best;
  endfunction

  // driver
  always @(posedge clk) begin
    palette_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (opcode == OP_WRITE) begin
          if (entry_index < PALETTE_SIZE) palette_model[entry_index] = {red, green, blue};
        end else begin
          expected_index_q.push_back(closest_entry(red, green, blue));
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!req_q[0].calm && $urandom_range(0, 7) == 0) begin
          send_gap <= int'($urandom_range(0, 13));
          in_valid <= 1'b0;
        end else begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          opcode <= nxt.op;
          entry_index <= nxt.idx;
          red <= nxt.color[23:16];
          green <= nxt.color[15:8];
          blue <= nxt.color[7:0];
          calm_phase <= nxt.calm;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [IDX_W-1:0] want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_index_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, got %0d", $time, nearest_index);
        end else begin
          want = expected_index_q.pop_front();
          if (nearest_index !== want) begin
            failures++;
            $display("%0t: nearest_index mismatch, expected %0d, got %0d",
                     $time, want, nearest_index);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        stall_left <= int'($urandom_range(0, 13));
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic palette_req_t make_req(input opcode_t op, input logic [IDX_W-1:0] idx,
                                            input logic [COLOR_W-1:0] color, input bit calm);
    palette_req_t p;
    p.op = op;
    p.idx = idx;
    p.color = color;
    p.calm = calm;
    return p;
  endfunction

  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || expected_index_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0] cluster [CLUSTER_N];
    logic [COLOR_W-1:0] color;
    logic [CHAN_W-1:0] c8;
    logic [IDX_W-1:0] idx;
    bit calm;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // full palette load: ramps, black and white at the ends, duplicated colors for ties
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      c8 = i[CHAN_W-1:0];
      color = {c8, ~c8, c8 * 8'd37};
      if (i == 0) color = 24'h000000;
      if (i == PALETTE_SIZE - 1) color = 24'hFFFFFF;
      if (i == 200) color = {8'd100, ~8'd100, 8'd100 * 8'd37};
      if (i == 77) color = {8'd9, ~8'd9, 8'd9 * 8'd37};
      req_q.push_back(make_req(OP_WRITE, i[IDX_W-1:0], color, 1'b0));
    end
    wait_drained();

    req_q.push_back(make_req(OP_QUERY, 8'h00, 24'h000000, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'hFF, 24'hFFFFFF, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'hA5, 24'hFF0000, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h5A, 24'h00FF00, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h0F, 24'h0000FF, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'hF0, 24'hFF00FF, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h33, 24'h00FFFF, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'hCC, 24'h808080, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h01, {8'd100, ~8'd100, 8'd100 * 8'd37}, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'hFE, {8'd9, ~8'd9, 8'd9 * 8'd37}, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h80, {8'd254, 8'd1, 8'd254 * 8'd37}, 1'b0));
    req_q.push_back(make_req(OP_QUERY, 8'h7F, 24'h7F7F7F, 1'b0));
    wait_drained();

    for (int blk = 0; blk < 4; blk++) begin
      calm = (blk == 3);
      for (int k = 0; k < CLUSTER_N; k++) cluster[k] = COLOR_W'($urandom_range(0, 24'hFFFFFF));
      for (int n = 0; n < 210; n++) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 3))
              0: idx = 8'd0;
              1: idx = 8'd1;
              2: idx = 8'd254;
              default: idx = 8'd255;
            endcase
          end else begin
            idx = IDX_W'($urandom_range(0, 255));
          end
          if ($urandom_range(0, 1) == 0) color = cluster[$urandom_range(0, CLUSTER_N - 1)];
          else color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
          req_q.push_back(make_req(OP_WRITE, idx, color, calm));
        end else begin
          case ($urandom_range(0, 3))
            0: color = COLOR_W'($urandom_range(0, 24'hFFFFFF));
            1: color = cluster[$urandom_range(0, CLUSTER_N - 1)];
            2: begin
              color = cluster[$urandom_range(0, CLUSTER_N - 1)];
              color[23:16] = color[23:16] + 8'($urandom_range(0, 6)) - 8'd3;
              color[15:8] = color[15:8] + 8'($urandom_range(0, 6)) - 8'd3;
              color[7:0] = color[7:0] + 8'($urandom_range(0, 6)) - 8'd3;
            end
            default: begin
              color[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              color[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
              color[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
          endcase
          idx = IDX_W'($urandom_range(0, 255));
          req_q.push_back(make_req(OP_QUERY, idx, color, calm));
        end
      end
      if (blk == 1) wait_drained();
    end

    wait_drained();
    repeat (PALETTE_SIZE + 20) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
